/* src/pnst_pkg.sv */
// Shared types and constants for the point-near-segment table test block.
`default_nettype none

package pnst_pkg;

  // Table depth and coordinate width.
  localparam int SEGMENTS   = 16;
  localparam int COORD_BITS = 16;

  // Fixed field widths on the stream ports.
  localparam int SLOT_BITS  = 4;
  localparam int FIELD_BITS = 16;
  localparam int IN_BITS    = SLOT_BITS + 6 * FIELD_BITS;
  localparam int IN_BYTES_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BYTES_W = 8;

  // Table index width, at least one bit.
  localparam int IDX_BITS = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

  // Compare width: two guard bits so widened spans never overflow.
  localparam int WIDE_BITS = COORD_BITS + 2;

  typedef logic [IDX_BITS-1:0]          idx_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;

  localparam wide_t ONE_W = wide_t'(1);

  // Item kinds carried in tuser.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // One stored segment.
  typedef struct packed {
    coord_t start_x;
    coord_t end_x;
    coord_t start_y;
    coord_t end_y;
  } seg_t;

  // Registered table read: the entry and whether it was ever written.
  typedef struct packed {
    logic valid;
    seg_t seg;
  } entry_t;

endpackage

`default_nettype wire

/* src/pnst_table.sv */
// Segment table: one write port, one registered read port, per-entry valid bits.
`default_nettype none

module pnst_table
  import pnst_pkg::*;
(
  input  wire    clk_i,
  input  wire    rst_ni,
  input  wire    wr_en_i,
  input  idx_t   wr_addr_i,
  input  seg_t   wr_seg_i,
  input  idx_t   rd_addr_i,
  output entry_t rd_entry_o
);

  seg_t                mem [SEGMENTS];
  logic [SEGMENTS-1:0] valid_q;
  seg_t                rd_seg_q;
  logic                rd_valid_q;

  // Segment storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_seg_i;
    end
    rd_seg_q <= mem[rd_addr_i];
  end

  // An entry never written reads with its valid bit clear, which never matches.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_entry_o = '{valid: rd_valid_q, seg: rd_seg_q};

endmodule

`default_nettype wire

/* src/pnst_match.sv */
// Shared compare unit: tests the query point against one table entry.
`default_nettype none

module pnst_match
  import pnst_pkg::*;
(
  input  entry_t entry_i,
  input  coord_t point_x_i,
  input  coord_t point_y_i,
  output logic   match_o
);

  wide_t sx, ex, sy, ey, px, py;
  wide_t across, fixed_c, along, span_s, span_e, lo, hi;
  logic  vert, horiz, across_ok, along_ok;

  // Widen everything by the guard bits.
  assign sx = wide_t'(entry_i.seg.start_x);
  assign ex = wide_t'(entry_i.seg.end_x);
  assign sy = wide_t'(entry_i.seg.start_y);
  assign ey = wide_t'(entry_i.seg.end_y);
  assign px = wide_t'(point_x_i);
  assign py = wide_t'(point_y_i);

  assign vert  = (ex == sx);
  assign horiz = (ey == sy);

  // A vertical segment is tested on x across and y along; otherwise the axes swap.
  always_comb begin
    if (vert) begin
      across  = px;
      fixed_c = ex;
      along   = py;
      span_s  = sy;
      span_e  = ey;
    end else begin
      across  = py;
      fixed_c = ey;
      along   = px;
      span_s  = sx;
      span_e  = ex;
    end
  end

  assign lo = (span_s < span_e) ? span_s : span_e;
  assign hi = (span_s < span_e) ? span_e : span_s;

  assign across_ok = (across >= fixed_c - ONE_W) && (across <= fixed_c + ONE_W);
  // A zero-length span is a single point and never matches.
  assign along_ok  = (span_s != span_e) && (along >= lo - ONE_W) && (along <= hi + ONE_W);

  assign match_o = entry_i.valid && (vert || horiz) && across_ok && along_ok;

endmodule

`default_nettype wire

/* src/point_near_segment_table_test_core.sv */
// Top level: stream ports, scan sequencer, segment table and compare unit.
//
//   Channel   Direction  Handshake            Contents
//   s_axis    in         tvalid/tready        tuser: opcode; tdata: slot and coordinates
//   m_axis    out        tvalid/tready        tdata: hit (one transfer per query)
//
// A write leaves the block idle, so it is ready again in the next cycle.
// A query scans the table after its transfer edge, and its result shows once
// the scan is through: one table entry is read per cycle and checked by the
// single compare unit.
// The block then holds the result until it is taken and accepts nothing meanwhile;
// it is ready again in the cycle after the result transfer.
// Reset clears the per-entry valid bits at once, so no clearing pass is needed.
// A stall on the output side only lengthens the wait before the next transfer.
`default_nettype none

module point_near_segment_table_test_core
  import pnst_pkg::*;
(
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // tdata from bit 0: slot[3:0], start_x[19:4], end_x[35:20], start_y[51:36],
  // end_y[67:52], point_x[83:68], point_y[99:84], zero fill to 104 bits.
  input  wire [IN_BYTES_W-1:0]   s_axis_tdata_i,
  // tuser from bit 0: opcode.
  input  wire                    s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  wire                    m_axis_tready_i,
  // tdata from bit 0: hit, zero fill to 8 bits.
  output logic [OUT_BYTES_W-1:0] m_axis_tdata_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_d, state_q;
  idx_t   cmp_idx_d, cmp_idx_q;
  logic   hit_d, hit_q;
  coord_t point_x_q, point_y_q;

  logic   in_xfer, out_xfer, is_query, wr_en, slot_ok, match, last_entry;
  idx_t   rd_addr, wr_addr;
  seg_t   wr_seg;
  entry_t rd_entry;
  logic [SLOT_BITS-1:0]          slot;
  logic [IDX_BITS+SLOT_BITS-1:0] slot_wide;

  // Unpack the input transfer.
  assign slot          = s_axis_tdata_i[SLOT_BITS-1:0];
  assign wr_seg.start_x = COORD_BITS'(s_axis_tdata_i[SLOT_BITS +: FIELD_BITS]);
  assign wr_seg.end_x   = COORD_BITS'(s_axis_tdata_i[SLOT_BITS + FIELD_BITS +: FIELD_BITS]);
  assign wr_seg.start_y = COORD_BITS'(s_axis_tdata_i[SLOT_BITS + 2*FIELD_BITS +: FIELD_BITS]);
  assign wr_seg.end_y   = COORD_BITS'(s_axis_tdata_i[SLOT_BITS + 3*FIELD_BITS +: FIELD_BITS]);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer        = m_axis_tvalid_o && m_axis_tready_i;
  assign is_query        = (s_axis_tuser_i == OP_QUERY);

  // Writes to a slot beyond the table are dropped.
  assign slot_wide = {{IDX_BITS{1'b0}}, slot};
  assign wr_addr   = slot_wide[IDX_BITS-1:0];
  assign slot_ok   = (int'(slot) < SEGMENTS);
  assign wr_en     = in_xfer && (s_axis_tuser_i == OP_WRITE) && slot_ok;

  // Read one entry ahead of the one being compared.
  assign rd_addr    = (state_q == ST_IDLE) ? idx_t'(0) : cmp_idx_q + 1'b1;
  assign last_entry = (cmp_idx_q == idx_t'(SEGMENTS - 1));

  pnst_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_seg_i   (wr_seg),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry)
  );

  pnst_match u_match (
    .entry_i   (rd_entry),
    .point_x_i (point_x_q),
    .point_y_i (point_y_q),
    .match_o   (match)
  );

  // Sequencer: one entry per cycle, hits accumulate into hit_q.
  always_comb begin
    state_d   = state_q;
    cmp_idx_d = cmp_idx_q;
    hit_d     = hit_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && is_query) begin
          state_d   = ST_SCAN;
          cmp_idx_d = '0;
          hit_d     = 1'b0;
        end
      end
      ST_SCAN: begin
        hit_d = hit_q || match;
        if (last_entry) begin
          state_d = ST_DONE;
        end else begin
          cmp_idx_d = cmp_idx_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_xfer) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmp_idx_q <= '0;
      hit_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_idx_q <= cmp_idx_d;
      hit_q     <= hit_d;
    end
  end

  // Query point, captured with the transfer.
  always_ff @(posedge clk_i) begin
    if (in_xfer && is_query) begin
      point_x_q <= COORD_BITS'(s_axis_tdata_i[SLOT_BITS + 4*FIELD_BITS +: FIELD_BITS]);
      point_y_q <= COORD_BITS'(s_axis_tdata_i[SLOT_BITS + 5*FIELD_BITS +: FIELD_BITS]);
    end
  end

  assign m_axis_tvalid_o = (state_q == ST_DONE);
  assign m_axis_tdata_o  = {{(OUT_BYTES_W-1){1'b0}}, hit_q};

endmodule

`default_nettype wire

/* src/pnst_checker.sv */
// Port-level checker for the top level, attached by bind.
`default_nettype none

module pnst_checker
  import pnst_pkg::*;
(
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    s_axis_tvalid_i,
  input wire                    s_axis_tready_o,
  input wire                    s_axis_tuser_i,
  input wire                    m_axis_tvalid_o,
  input wire                    m_axis_tready_i,
  input wire [OUT_BYTES_W-1:0]  m_axis_tdata_o
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // A pending result blocks new input.
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input ready while a result is pending");

  // A query starts a scan, so the block is busy in the next cycle.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tuser_i == OP_QUERY) |=> (!s_axis_tready_o && !m_axis_tvalid_o))
    else $error("query did not start a scan");

  // A write gives no result and leaves the block ready.
  a_write_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tuser_i == OP_WRITE) |=> (s_axis_tready_o && !m_axis_tvalid_o))
    else $error("write produced a result or stalled");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

  // Result fill bits stay zero.
  a_out_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[OUT_BYTES_W-1:1] == '0))
    else $error("result fill bits not zero");

endmodule

bind point_near_segment_table_test_core pnst_checker u_pnst_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
